// File: sv/vfc_pkg.sv
// vfc_pkg: shared types, constants and lookup tables for the voxel face cull emitter
// depends on nothing; imported by every module of the block
package vfc_pkg;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int FACE_COUNT = 6;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL    = 2'd0,
        CFG_EXTENT_X = 2'd1,
        CFG_EXTENT_Y = 2'd2,
        CFG_EXTENT_Z = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        FACE_FRONT  = 3'd0,
        FACE_LEFT   = 3'd1,
        FACE_BACK   = 3'd2,
        FACE_RIGHT  = 3'd3,
        FACE_TOP    = 3'd4,
        FACE_BOTTOM = 3'd5
    } face_t;

    typedef enum logic [1:0] {
        COLOR_BLUE  = 2'd0,
        COLOR_GREEN = 2'd1,
        COLOR_WHITE = 2'd2
    } color_t;

    localparam logic [2:0] LAST_STEP = 3'd5;

    // corner sign per face and corner, bit 0 x .. bit 2 z, 1 means plus extent
    localparam logic [2:0] CORNER_SIGN [FACE_COUNT][4] = '{
        '{3'b110, 3'b111, 3'b101, 3'b100},
        '{3'b110, 3'b100, 3'b000, 3'b010},
        '{3'b011, 3'b010, 3'b000, 3'b001},
        '{3'b111, 3'b011, 3'b001, 3'b101},
        '{3'b111, 3'b110, 3'b010, 3'b011},
        '{3'b101, 3'b001, 3'b000, 3'b100}
    };

    // two triangles over the four corners
    localparam logic [1:0] TRI_ORDER [FACE_COUNT] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};

    function automatic color_t face_color(input face_t f);
        color_t c;
        begin
            case (f)
                FACE_FRONT, FACE_BACK: c = COLOR_BLUE;
                FACE_LEFT, FACE_RIGHT: c = COLOR_GREEN;
                FACE_TOP, FACE_BOTTOM: c = COLOR_WHITE;
                default:               c = COLOR_BLUE;
            endcase
            return c;
        end
    endfunction

endpackage

// File: sv/vfc_front.sv
// vfc_front: accepts cell beats and builds the mask of faces to emit
// depends on vfc_pkg; feeds vfc_queue
module vfc_front
    import vfc_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int VALUE_WIDTH = 16
)
(
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [3*COORD_WIDTH-1:0]   centers,
    input  logic [VALUE_WIDTH-1:0]     own_value,
    input  logic [6*VALUE_WIDTH-1:0]   nb_values,
    input  logic [CFG_W-1:0]           level,
    input  logic                       q_full,
    output logic                       q_push,
    output logic [3*COORD_WIDTH+5:0]   q_data
);

    localparam int CMP_W = (VALUE_WIDTH > CFG_W) ? VALUE_WIDTH : CFG_W;

    logic [CMP_W-1:0]      level_ext;
    logic [CMP_W-1:0]      own_ext;
    logic                  own_below;
    logic [FACE_COUNT-1:0] mask;

    assign level_ext = CMP_W'(level);
    assign own_ext   = CMP_W'(own_value);
    assign own_below = own_ext < level_ext;

    always_comb
    begin
        for (int f = 0; f < FACE_COUNT; f++)
        begin
            mask[f] = own_below &&
                      (CMP_W'(nb_values[f*VALUE_WIDTH +: VALUE_WIDTH]) >= level_ext);
        end
    end

    // beats with no face give no result and are dropped here
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full && (mask != '0);
    assign q_data   = {mask, centers};

endmodule

// File: sv/vfc_queue.sv
// vfc_queue: two-entry register queue between the front and the back
// depends on vfc_pkg
module vfc_queue
    import vfc_pkg::*;
#(
    parameter int WIDTH = 78
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]  mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = count_reg == QCNT_W'(QDEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");
`endif

endmodule

// File: sv/vfc_back.sv
// vfc_back: walks the face mask of one cell and emits six vertex beats per face
// depends on vfc_pkg; drains vfc_queue
module vfc_back
    import vfc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_not_empty,
    input  logic [3*COORD_WIDTH+5:0]   q_data,
    output logic                       q_pop,
    input  logic [CFG_W-1:0]           extent [3],
    output logic                       out_valid,
    input  logic                       out_ready,
    output face_t                      out_face,
    output color_t                     out_color,
    output logic [3*COORD_WIDTH-1:0]   out_vertex,
    output logic                       out_last
);

    localparam int SUM_W = ((COORD_WIDTH > CFG_W + 1) ? COORD_WIDTH : CFG_W + 1) + 1;

    logic                     busy_reg;
    logic                     busy_next;
    logic [FACE_COUNT-1:0]    mask_reg;
    logic [FACE_COUNT-1:0]    mask_next;
    logic [2:0]               step_reg;
    logic [2:0]               step_next;
    logic [3*COORD_WIDTH-1:0] center_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    face_t                    out_face_reg;
    color_t                   out_color_reg;
    logic [3*COORD_WIDTH-1:0] out_vertex_reg;
    logic                     out_last_reg;

    logic                     adv;
    logic [2:0]               face_idx;
    face_t                    face;
    logic [FACE_COUNT-1:0]    rest_mask;
    logic                     face_last;
    logic                     item_last;
    logic                     load;
    logic [2:0]               signs;
    logic [3*COORD_WIDTH-1:0] vertex;

    always_comb
    begin
        face_idx = 3'd0;
        for (int f = FACE_COUNT - 1; f >= 0; f--)
        begin
            if (mask_reg[f])
            begin
                face_idx = 3'(f);
            end
        end
    end

    assign face      = face_t'(face_idx);
    assign rest_mask = mask_reg & ~(FACE_COUNT'(1) << face_idx);
    assign face_last = step_reg == LAST_STEP;
    assign item_last = face_last && (rest_mask == '0);
    assign adv       = busy_reg && (!out_valid_reg || out_ready);
    assign load      = q_not_empty && (!busy_reg || (adv && item_last));
    assign q_pop     = load;
    assign signs     = CORNER_SIGN[face_idx][TRI_ORDER[step_reg]];

    generate
        for (genvar a = 0; a < 3; a++)
        begin : g_axis
            logic signed [SUM_W-1:0] c_ext;
            logic signed [SUM_W-1:0] e_ext;
            logic signed [SUM_W-1:0] sum;
            logic [COORD_WIDTH-1:0]  sat;
            always_comb
            begin
                c_ext = SUM_W'($signed(center_reg[a*COORD_WIDTH +: COORD_WIDTH]));
                e_ext = $signed({{(SUM_W-CFG_W){1'b0}}, extent[a]});
                sum   = signs[a] ? c_ext + e_ext : c_ext - e_ext;
                if (sum[SUM_W-1:COORD_WIDTH-1] == '0 || sum[SUM_W-1:COORD_WIDTH-1] == '1)
                begin
                    sat = sum[COORD_WIDTH-1:0];
                end
                else if (sum[SUM_W-1])
                begin
                    sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
                end
                else
                begin
                    sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
                end
            end
            assign vertex[a*COORD_WIDTH +: COORD_WIDTH] = sat;
        end
    endgenerate

    always_comb
    begin
        busy_next = busy_reg;
        mask_next = mask_reg;
        step_next = step_reg;
        if (adv)
        begin
            if (face_last)
            begin
                mask_next = rest_mask;
                step_next = 3'd0;
                if (item_last)
                begin
                    busy_next = 1'b0;
                end
            end
            else
            begin
                step_next = step_reg + 3'd1;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            mask_next = q_data[3*COORD_WIDTH +: FACE_COUNT];
            step_next = 3'd0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            mask_reg      <= '0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            mask_reg      <= mask_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            center_reg <= q_data[3*COORD_WIDTH-1:0];
        end
        if (adv)
        begin
            out_face_reg   <= face;
            out_color_reg  <= face_color(face);
            out_vertex_reg <= vertex;
            out_last_reg   <= item_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_face   = out_face_reg;
    assign out_color  = out_color_reg;
    assign out_vertex = out_vertex_reg;
    assign out_last   = out_last_reg;

`ifndef NO_ASSERTIONS
    a_busy_has_faces: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (mask_reg != '0))
        else $error("working on a cell with no faces left");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= LAST_STEP)
        else $error("vertex step out of range");
    a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !face_last && !load) |=> (step_reg == $past(step_reg) + 3'd1))
        else $error("vertex step did not advance");
    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && busy_reg) |-> (adv && item_last))
        else $error("queue popped before the current cell finished");
`endif

endmodule

// File: sv/voxel_face_cull_emitter.sv
// voxel_face_cull_emitter: culls the six faces of a voxel cell and emits two triangles per face
// the first vertex beat passes the queue, walker state and output register in turn
// one vertex beat per cycle unless m_axis_tready stalls; a cell with k faces gives 6*k beats
// cells with no visible face are accepted and give no beat
// a two-entry queue lets cell beats be taken while vertices drain
// rst_n asynchronous active low; registers reset to level 32768 and extents 128
module voxel_face_cull_emitter
    import vfc_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int VALUE_WIDTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // center_x, center_y, center_z, own_value, front_value, left_value,
    // back_value, right_value, top_value, bottom_value, zero fill
    input  logic [((3*COORD_WIDTH+7*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // vertex_x, vertex_y, vertex_z, zero fill
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // face, color_code
    output logic [4:0]              m_axis_tuser,
    output logic                    m_axis_tlast
);

    localparam int IN_W  = ((3*COORD_WIDTH+7*VALUE_WIDTH+7)/8)*8;
    localparam int OUT_W = ((3*COORD_WIDTH+7)/8)*8;
    localparam int Q_W   = 3*COORD_WIDTH + FACE_COUNT;

    logic [CFG_W-1:0]         level_reg;
    logic [CFG_W-1:0]         extent_reg [3];
    logic                     q_full;
    logic                     q_push;
    logic [Q_W-1:0]           q_wdata;
    logic                     q_pop;
    logic                     q_not_empty;
    logic [Q_W-1:0]           q_rdata;
    face_t                    out_face;
    color_t                   out_color;
    logic [3*COORD_WIDTH-1:0] out_vertex;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= CFG_W'(32768);
            extent_reg[0] <= CFG_W'(128);
            extent_reg[1] <= CFG_W'(128);
            extent_reg[2] <= CFG_W'(128);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LEVEL:    level_reg     <= cfg_data;
                CFG_EXTENT_X: extent_reg[0] <= cfg_data;
                CFG_EXTENT_Y: extent_reg[1] <= cfg_data;
                CFG_EXTENT_Z: extent_reg[2] <= cfg_data;
                default:      level_reg     <= level_reg;
            endcase
        end
    end

    vfc_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .centers   (s_axis_tdata[3*COORD_WIDTH-1:0]),
        .own_value (s_axis_tdata[3*COORD_WIDTH +: VALUE_WIDTH]),
        .nb_values (s_axis_tdata[3*COORD_WIDTH+VALUE_WIDTH +: 6*VALUE_WIDTH]),
        .level     (level_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    vfc_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_rdata)
    );

    vfc_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .extent      (extent_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_face    (out_face),
        .out_color   (out_color),
        .out_vertex  (out_vertex),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'(out_vertex);
    assign m_axis_tuser = {out_color, out_face};

`ifndef NO_ASSERTIONS
    a_in_width: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (IN_W >= 3*COORD_WIDTH+7*VALUE_WIDTH))
        else $error("input beat narrower than its fields");
    a_out_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (face_color(out_face) == out_color))
        else $error("color does not match face");
    a_cull_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (s_axis_tvalid && s_axis_tready))
        else $error("queue written without an accepted beat");
`endif

endmodule
